// File: sv/current_loop_input_conditioner_assert.svh
// Assertion macros used by the checker file of the current loop conditioner.
`ifndef CURRENT_LOOP_INPUT_CONDITIONER_ASSERT_SVH
`define CURRENT_LOOP_INPUT_CONDITIONER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CLI_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cli assertion failed");

// Next-cycle implication, disabled while reset is high.
`define CLI_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cli assertion failed");

`endif

// File: sv/cli_pkg.sv
// Shared constants, codes and interface types of the current loop input conditioner.
package cli_pkg;

   // Table storage
   localparam int TABLE_DEPTH = 128;
   localparam int IDX_W       = 7;
   localparam int POINT_W     = 12;
   localparam int CORR_W      = 8;
   localparam int SIZE_W      = 8;

   // Sample group: position 0 is dropped, 1..6 are kept
   localparam int POS_W       = 3;
   localparam int GROUP_LAST  = 6;
   localparam int SUM_W       = 15;

   // Field widths
   localparam int CODE_W      = 12;
   localparam int CUR_W       = 12;
   localparam int CAL_W       = 13;
   localparam int VAL_W       = 16;
   localparam int OFF_W       = 11;

   // Request codes
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_TABLE  = 1'b1;

   // Register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_MIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_MAX  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_SIZE = 2'd2;
   localparam logic [SIZE_W-1:0]    TABLE_SIZE_RST = 8'd81;

   // floor(floor(330000*c/4095)/150) == floor(440*c/819)
   localparam int RAW_MUL     = 440;
   localparam int DEN_W       = 11;
   localparam int D_RAW       = 819;
   localparam int D_SCALE     = 1600;   // 2000 - 400
   localparam int LOOP_LOW    = 400;

   // Constant division by reciprocal multiply plus one correction step
   localparam int DIV_W       = 27;
   localparam int RECIP_W     = 23;
   localparam int RECIP_SHIFT = 32;
   localparam int QUOT_W      = 18;
   localparam logic [RECIP_W-1:0] RECIP_RAW =
      RECIP_W'((64'd1 << RECIP_SHIFT) / D_RAW);
   localparam logic [RECIP_W-1:0] RECIP_SCALE =
      RECIP_W'((64'd1 << RECIP_SHIFT) / D_SCALE);

   // Table entry write
   typedef struct packed {
      logic               en;
      logic [IDX_W-1:0]   index;
      logic [POINT_W-1:0] point;
      logic [CORR_W-1:0]  correction;
   } cal_write_type;

   // Nearest-point search request
   typedef struct packed {
      logic               start;
      logic [CUR_W-1:0]   target;
      logic [SIZE_W-1:0]  size;
   } search_req_type;

   // Table status and search result
   typedef struct packed {
      logic                     ready;
      logic                     done;
      logic signed [CORR_W-1:0] correction;
   } search_rsp_type;

endpackage

// File: sv/current_loop_input_conditioner.sv
// Top level of the 4-20 mA loop input conditioner: sample groups, conversion and scaling.
// A table write or a sample that does not end a group leaves the input unstalled.
// The seventh sample of a group starts trim, conversion, table search and scaling;
// the search reads one table entry per cycle from the calibration RAM.
// One result per seven samples; the input stalls until each group's result is registered.
// Reset: synchronous; afterwards a clearing pass zeroes every table entry
// while the input is stalled. Configuration registers reset to 0, 0 and 81.
module current_loop_input_conditioner #(
   parameter int TABLE_DEPTH = cli_pkg::TABLE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Configuration
   input  logic                                  csr_wr_en,
   input  logic [cli_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [cli_pkg::VAL_W-1:0]             csr_wdata,
   // Request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_type,
   input  logic [cli_pkg::CODE_W-1:0]            req_sample,
   input  logic [cli_pkg::IDX_W-1:0]             req_table_index,
   input  logic [cli_pkg::POINT_W-1:0]           req_table_point,
   input  logic signed [cli_pkg::CORR_W-1:0]     req_table_correction,
   // Response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [cli_pkg::CODE_W-1:0]            rsp_filtered_code,
   output logic [cli_pkg::CUR_W-1:0]             rsp_raw_current,
   output logic signed [cli_pkg::CAL_W-1:0]      rsp_calibrated_current,
   output logic signed [cli_pkg::VAL_W-1:0]      rsp_scaled_value
);
   import cli_pkg::*;

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] ST_CLEAR  = 4'd0;
   localparam logic [ST_W-1:0] ST_IDLE   = 4'd1;
   localparam logic [ST_W-1:0] ST_TRIM   = 4'd2;
   localparam logic [ST_W-1:0] ST_MUL    = 4'd3;
   localparam logic [ST_W-1:0] ST_QE     = 4'd4;
   localparam logic [ST_W-1:0] ST_FIX    = 4'd5;
   localparam logic [ST_W-1:0] ST_SEARCH = 4'd6;
   localparam logic [ST_W-1:0] ST_SCALE  = 4'd7;
   localparam logic [ST_W-1:0] ST_DONE   = 4'd8;

   localparam int PROD_W = DIV_W + RECIP_W;
   localparam int QD_W   = QUOT_W + DEN_W;

   // Control registers
   logic [ST_W-1:0]  state_ff, state_in;
   logic             phase_ff, phase_in;       // 0: current conversion, 1: scaling
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Configuration
   logic signed [VAL_W-1:0] range_min_ff, range_max_ff;
   logic [SIZE_W-1:0]       table_size_ff;

   // Group accumulators
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CODE_W-1:0] max_ff, max_in, min_ff, min_in;

   // Datapath registers
   logic [CODE_W-1:0]       code_ff, code_in;
   logic [CUR_W-1:0]        raw_ff, raw_in;
   logic signed [CAL_W-1:0] cal_ff, cal_in;
   logic signed [VAL_W-1:0] scaled_ff, scaled_in;
   logic [DIV_W-1:0]        x_ff, x_in;
   logic [QUOT_W-1:0]       qe_ff, qe_in;
   logic                    span_neg_ff, span_neg_in;
   logic [VAL_W-1:0]        span_mag_ff, span_mag_in;

   // Output registers
   logic [CODE_W-1:0]       rsp_code_ff, rsp_code_in;
   logic [CUR_W-1:0]        rsp_raw_ff, rsp_raw_in;
   logic signed [CAL_W-1:0] rsp_cal_ff, rsp_cal_in;
   logic signed [VAL_W-1:0] rsp_val_ff, rsp_val_in;

   // Combinational helpers
   logic                    req_acc;
   logic [SUM_W-1:0]        trim_c;
   logic signed [VAL_W:0]   span_c;
   logic [RECIP_W-1:0]      recip_sel;
   logic [DEN_W-1:0]        den_sel;
   logic [PROD_W-1:0]       qprod;
   logic [QD_W-1:0]         qd_full;
   logic [DIV_W-1:0]        rem_c;
   logic [QUOT_W-1:0]       quot_c;
   logic signed [QUOT_W-1:0] sval_c;
   logic signed [QUOT_W-1:0] ssum_c;
   logic signed [CAL_W-1:0] cal_off_c;
   logic                    rsp_free;

   cal_write_type  tbl_wr;
   search_req_type srch_req;
   search_rsp_type srch_rsp;

   cli_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_cli_table (
      .clock    (clock),
      .reset    (reset),
      .wr       (tbl_wr),
      .srch_req (srch_req),
      .srch_rsp (srch_rsp)
   );

   // Handshake
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid & ~req_stall;
   assign rsp_free  = ~rsp_valid_ff | ~rsp_stall;

   // Table writes go straight to the RAM; out-of-range indexes are dropped
   assign tbl_wr.en         = req_acc && (req_type == REQ_TABLE) &&
                              (32'(req_table_index) < TABLE_DEPTH);
   assign tbl_wr.index      = req_table_index;
   assign tbl_wr.point      = req_table_point;
   assign tbl_wr.correction = req_table_correction;

   // Search starts once the raw current is known
   assign srch_req.start  = (state_ff == ST_FIX) && (phase_ff == 1'b0);
   assign srch_req.target = quot_c[CUR_W-1:0];
   assign srch_req.size   = table_size_ff;

   // Trimmed sum and range span
   assign trim_c = sum_ff - SUM_W'(max_ff) - SUM_W'(min_ff);
   assign span_c = (VAL_W + 1)'(range_max_ff) - (VAL_W + 1)'(range_min_ff);

   // Shared constant divider: reciprocal estimate then one correction
   assign recip_sel = phase_ff ? RECIP_SCALE : RECIP_RAW;
   assign den_sel   = phase_ff ? DEN_W'(D_SCALE) : DEN_W'(D_RAW);
   assign qprod     = PROD_W'(x_ff) * PROD_W'(recip_sel);
   assign qd_full   = QD_W'(qe_ff) * QD_W'(den_sel);
   assign rem_c     = x_ff - DIV_W'(qd_full);
   assign quot_c    = qe_ff + QUOT_W'(rem_c >= DIV_W'(den_sel));

   // Signed scaled result, truncated toward zero, wrapped to 16 bits
   assign sval_c    = span_neg_ff ? -$signed(quot_c) : $signed(quot_c);
   assign ssum_c    = sval_c + QUOT_W'(range_min_ff);
   assign cal_off_c = cal_ff - CAL_W'(LOOP_LOW);

   // Main sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      sum_in       = sum_ff;
      max_in       = max_ff;
      min_in       = min_ff;
      code_in      = code_ff;
      raw_in       = raw_ff;
      cal_in       = cal_ff;
      scaled_in    = scaled_ff;
      x_in         = x_ff;
      qe_in        = qe_ff;
      span_neg_in  = span_neg_ff;
      span_mag_in  = span_mag_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_code_in  = rsp_code_ff;
      rsp_raw_in   = rsp_raw_ff;
      rsp_cal_in   = rsp_cal_ff;
      rsp_val_in   = rsp_val_ff;

      case (state_ff)
         ST_CLEAR: begin
            if (srch_rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc && (req_type == REQ_SAMPLE)) begin
               if (pos_ff == '0) begin
                  pos_in = POS_W'(1);
               end else if (pos_ff == POS_W'(1)) begin
                  sum_in = SUM_W'(req_sample);
                  max_in = req_sample;
                  min_in = req_sample;
                  pos_in = POS_W'(2);
               end else begin
                  sum_in = sum_ff + SUM_W'(req_sample);
                  if (req_sample > max_ff) begin
                     max_in = req_sample;
                  end
                  if (req_sample < min_ff) begin
                     min_in = req_sample;
                  end
                  if (pos_ff == POS_W'(GROUP_LAST)) begin
                     pos_in   = '0;
                     state_in = ST_TRIM;
                  end else begin
                     pos_in = pos_ff + POS_W'(1);
                  end
               end
            end
         end
         ST_TRIM: begin
            code_in     = trim_c[CODE_W+1:2];
            span_neg_in = span_c[VAL_W];
            span_mag_in = span_c[VAL_W] ? VAL_W'(-span_c) : VAL_W'(span_c);
            state_in    = ST_MUL;
         end
         ST_MUL: begin
            x_in     = DIV_W'(code_ff) * DIV_W'(RAW_MUL);
            phase_in = 1'b0;
            state_in = ST_QE;
         end
         ST_QE: begin
            qe_in    = qprod[RECIP_SHIFT +: QUOT_W];
            state_in = ST_FIX;
         end
         ST_FIX: begin
            if (phase_ff == 1'b0) begin
               raw_in   = quot_c[CUR_W-1:0];
               state_in = ST_SEARCH;
            end else begin
               scaled_in = ssum_c[VAL_W-1:0];
               state_in  = ST_DONE;
            end
         end
         ST_SEARCH: begin
            if (srch_rsp.done) begin
               cal_in   = $signed({1'b0, raw_ff}) - CAL_W'(srch_rsp.correction);
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            // Below 4 mA the engineering value is zero
            if (cal_ff >= CAL_W'(LOOP_LOW)) begin
               x_in     = DIV_W'(cal_off_c[OFF_W-1:0]) * DIV_W'(span_mag_ff);
               phase_in = 1'b1;
               state_in = ST_QE;
            end else begin
               scaled_in = '0;
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = code_ff;
               rsp_raw_in   = raw_ff;
               rsp_cal_in   = cal_ff;
               rsp_val_in   = scaled_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         phase_ff      <= 1'b0;
         pos_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         range_min_ff  <= '0;
         range_max_ff  <= '0;
         table_size_ff <= TABLE_SIZE_RST;
         sum_ff        <= '0;
         max_ff        <= '0;
         min_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_RANGE_MIN:  range_min_ff  <= $signed(csr_wdata);
               CSR_RANGE_MAX:  range_max_ff  <= $signed(csr_wdata);
               CSR_TABLE_SIZE: table_size_ff <= csr_wdata[SIZE_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      raw_ff      <= raw_in;
      cal_ff      <= cal_in;
      scaled_ff   <= scaled_in;
      x_ff        <= x_in;
      qe_ff       <= qe_in;
      span_neg_ff <= span_neg_in;
      span_mag_ff <= span_mag_in;
      rsp_code_ff <= rsp_code_in;
      rsp_raw_ff  <= rsp_raw_in;
      rsp_cal_ff  <= rsp_cal_in;
      rsp_val_ff  <= rsp_val_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_filtered_code      = rsp_code_ff;
   assign rsp_raw_current        = rsp_raw_ff;
   assign rsp_calibrated_current = rsp_cal_ff;
   assign rsp_scaled_value       = rsp_val_ff;

endmodule

// File: sv/cli_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cli_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/cli_table.sv
// Calibration table: clearing pass, entry writes and nearest-point search.
module cli_table #(
   parameter int TABLE_DEPTH = cli_pkg::TABLE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cli_pkg::cal_write_type  wr,
   input  cli_pkg::search_req_type srch_req,
   output cli_pkg::search_rsp_type srch_rsp
);
   import cli_pkg::*;

   localparam int AW     = $clog2(TABLE_DEPTH);
   localparam int CW     = $clog2(TABLE_DEPTH + 1);
   localparam int WORD_W = POINT_W + CORR_W;

   // Clearing pass
   logic          clr_ff, clr_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   // Read issue
   logic          act_ff, act_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] last_ff, last_in;
   logic [CUR_W-1:0] target_ff, target_in;

   // Compare stage
   logic          rd_vld_ff, rd_first_ff, rd_last_ff;
   logic [POINT_W-1:0]      best_dist_ff, best_dist_in;
   logic signed [CORR_W-1:0] best_corr_ff, best_corr_in;
   logic          done_ff;

   logic [CW-1:0]     count_c;
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [WORD_W-1:0] ram_wdata;
   logic [WORD_W-1:0] ram_rdata;
   logic [POINT_W-1:0] rd_point;
   logic [CORR_W-1:0]  rd_corr;
   logic signed [CAL_W-1:0] diff;
   logic [POINT_W-1:0] dist_c;
   logic              issue_last;

   // Clamp the entry count to 1..TABLE_DEPTH
   always_comb begin
      if (srch_req.size == '0) begin
         count_c = CW'(1);
      end else if (32'(srch_req.size) > TABLE_DEPTH) begin
         count_c = CW'(TABLE_DEPTH);
      end else begin
         count_c = CW'(srch_req.size);
      end
   end

   // Write port: clearing pass has priority
   assign ram_we    = clr_ff | wr.en;
   assign ram_waddr = clr_ff ? clr_addr_ff : AW'(wr.index);
   assign ram_wdata = clr_ff ? '0 : {wr.point, wr.correction};

   cli_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_DEPTH)
   ) u_cli_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (ram_rdata)
   );

   // Clearing pass sequencing
   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(TABLE_DEPTH - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   // Read issue: one entry per cycle
   assign issue_last = (idx_ff == last_ff);

   always_comb begin
      act_in    = act_ff;
      idx_in    = idx_ff;
      last_in   = last_ff;
      target_in = target_ff;
      if (srch_req.start) begin
         act_in    = 1'b1;
         idx_in    = '0;
         last_in   = count_c - CW'(1);
         target_in = srch_req.target;
      end else if (act_ff) begin
         idx_in = idx_ff + CW'(1);
         if (issue_last) begin
            act_in = 1'b0;
         end
      end
   end

   // Distance compare: first smallest wins
   assign rd_point = ram_rdata[WORD_W-1 -: POINT_W];
   assign rd_corr  = ram_rdata[CORR_W-1:0];
   assign diff     = $signed({1'b0, target_ff}) - $signed({1'b0, rd_point});
   assign dist_c   = diff[CAL_W-1] ? POINT_W'(-diff) : POINT_W'(diff);

   always_comb begin
      best_dist_in = best_dist_ff;
      best_corr_in = best_corr_ff;
      if (rd_vld_ff && (rd_first_ff || (dist_c < best_dist_ff))) begin
         best_dist_in = dist_c;
         best_corr_in = $signed(rd_corr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
         act_ff      <= 1'b0;
         rd_vld_ff   <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
         act_ff      <= act_in;
         rd_vld_ff   <= act_ff;
         done_ff     <= rd_vld_ff & rd_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      last_ff      <= last_in;
      target_ff    <= target_in;
      rd_first_ff  <= (idx_ff == '0);
      rd_last_ff   <= issue_last;
      best_dist_ff <= best_dist_in;
      best_corr_ff <= best_corr_in;
   end

   assign srch_rsp.ready      = ~clr_ff;
   assign srch_rsp.done       = done_ff;
   assign srch_rsp.correction = best_corr_ff;

endmodule

// File: sv/cli_checker.sv
// Port-level checks of the current loop input conditioner, bound to the top level.
`include "current_loop_input_conditioner_assert.svh"

module cli_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic                                  req_type,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic [cli_pkg::CODE_W-1:0]            rsp_filtered_code,
   input  logic signed [cli_pkg::CAL_W-1:0]      rsp_calibrated_current,
   input  logic signed [cli_pkg::VAL_W-1:0]      rsp_scaled_value
);
   import cli_pkg::*;

   // A new result only comes out of a busy period
   `CLI_ASSERT_IMPL(a_rsp_after_busy, clock, reset, $rose(rsp_valid), $past(req_stall))

   // A table write transaction does not stall the next one
   `CLI_ASSERT_NEXT(a_table_wr_no_stall, clock, reset,
      req_valid && !req_stall && (req_type == REQ_TABLE), !req_stall)

   // Below 4 mA the engineering value is zero
   `CLI_ASSERT_IMPL(a_below_range_zero, clock, reset,
      rsp_valid && (rsp_calibrated_current < CAL_W'(LOOP_LOW)), rsp_scaled_value == '0)

   // A stalled result holds
   `CLI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_filtered_code) && $stable(rsp_scaled_value))

endmodule

bind current_loop_input_conditioner cli_checker u_cli_checker (.*);
